// ===== rtl/ipcs_pkg.sv =====
// ============================================================================
// ipcs_pkg: shared types and helpers for the IPv4/TCP checksum stream core
// Word widths, header field positions and the end-around-carry adder.
// ============================================================================
package ipcs_pkg;

    localparam int WORD_W  = 16;
    localparam int INDEX_W = 15;
    localparam int IHL_W   = 4;
    localparam int PROTO_W = 8;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [IHL_W-1:0]   ihl_t;
    typedef logic [PROTO_W-1:0] proto_t;

    localparam word_t  LOW_BYTE_MASK = 16'h00ff;
    localparam word_t  WORD_MASK     = 16'hffff;
    localparam index_t INDEX_MAX     = 15'h7fff;

    // Fixed word positions inside the IPv4 header
    localparam index_t IDX_IHL        = 15'd0;
    localparam index_t IDX_TOTAL_LEN  = 15'd1;
    localparam index_t IDX_PROTOCOL   = 15'd4;
    localparam index_t IDX_IP_CHECK   = 15'd5;
    localparam index_t IDX_ADDR_FIRST = 15'd6;
    localparam index_t IDX_ADDR_LAST  = 15'd9;
    localparam index_t IDX_FIRST_VAR  = 15'd2;

    // TCP check word sits this many words into the segment
    localparam index_t TCP_CHECK_OFS  = 15'd8;
    localparam ihl_t   IHL_MIN        = 4'd5;

    // Ones'-complement add with end-around carry
    function automatic word_t oc_add(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        logic [WORD_W:0] f;
        begin
            s = {1'b0, a} + {1'b0, b};
            f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
            oc_add = f[WORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/ipv4_tcp_checksum_stream_core.sv =====
// ============================================================================
// ipv4_tcp_checksum_stream_core: streaming IPv4 header and TCP checksums
// Sums one IPv4/TCP packet word by word and reports both checksums at its end.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, word, last) carries the packet as
//   big-endian 16-bit words; last marks the final word of a packet.
//   Output channel (out_valid/out_ready, ip_checksum, tcp_checksum,
//   length_error) carries one result per packet, after its last word.
//   Throughput: one word per cycle unless a last word waits for the output
//   register, set by the single pass from the input register through both
//   running-sum adders into the state (or, on a last word, result) registers.
//   Back-pressure: a finished result waits in the output register; non-last
//   words keep flowing while it waits. Only a last word finding the output
//   register still full holds in the input register, and in_ready drops
//   until the receiver takes the pending result.
//   Reset clears the running sums, word counter and both valid flags; the
//   block then expects the first word of a new packet.
//   Words past the IP total length, or past word 32767, do not count.
// ============================================================================
module ipv4_tcp_checksum_stream_core
    import ipcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] word,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] ip_checksum,
    output logic [15:0] tcp_checksum,
    output logic        length_error
);

    // Input register
    logic   in_valid_reg;
    word_t  word_reg;
    logic   last_reg;

    // Per-packet state
    index_t word_index_reg, word_index_next;
    logic   past_end_reg, past_end_next;
    ihl_t   header_words_reg, header_words_next;
    word_t  total_length_reg, total_length_next;
    proto_t protocol_reg, protocol_next;
    word_t  ip_sum_reg, ip_sum_next;
    word_t  tcp_sum_reg, tcp_sum_next;

    // Result register
    logic   out_valid_reg;
    word_t  ip_checksum_reg, ip_checksum_next;
    word_t  tcp_checksum_reg, tcp_checksum_next;
    logic   length_error_reg, length_error_next;

    logic   advance;
    logic   result_free;

    // Datapath temporaries
    word_t          bytes;
    word_t          w_eff;
    logic           in_range;
    logic [5:0]     hdr_end;
    logic [6:0]     tcp_check_idx;
    logic           take_ip, take_addr, take_seg;
    word_t          tcp_mid;
    word_t          seg_len;
    word_t          tcp_fin;
    logic [15:0]    count;
    logic [16:0]    count_bytes;

    // Result register frees when empty or being drained this cycle
    assign result_free = !out_valid_reg || out_ready;
    // Non-last words never wait; a last word waits for room in the result register
    assign advance     = in_valid_reg && (!last_reg || result_free);
    assign in_ready    = !in_valid_reg || advance;

    always_comb
    begin
        word_index_next   = word_index_reg;
        past_end_next     = past_end_reg;
        header_words_next = header_words_reg;
        total_length_next = total_length_reg;
        protocol_next     = protocol_reg;
        ip_sum_next       = ip_sum_reg;
        tcp_sum_next      = tcp_sum_reg;

        bytes         = {word_index_reg, 1'b0};
        in_range      = 1'b0;
        w_eff         = word_reg;
        hdr_end       = 6'd0;
        tcp_check_idx = 7'd0;
        take_ip       = 1'b0;
        take_addr     = 1'b0;
        take_seg      = 1'b0;
        tcp_mid       = tcp_sum_reg;

        if (!past_end_reg)
        begin
            // Latch header fields as they pass, before classing the word
            if (word_index_reg == IDX_IHL)
                header_words_next = word_reg[11:8];
            if (word_index_reg == IDX_TOTAL_LEN)
                total_length_next = word_reg;
            if (word_index_reg == IDX_PROTOCOL)
                protocol_next = proto_t'(word_reg & LOW_BYTE_MASK);

            in_range = (word_index_reg < IDX_FIRST_VAR) || (bytes < total_length_next);

            // Odd final byte: pad the low byte with zero
            if ((word_index_reg >= IDX_FIRST_VAR) &&
                ({word_index_reg, 1'b1} == total_length_next))
                w_eff = word_reg & ~LOW_BYTE_MASK;

            hdr_end       = {1'b0, header_words_next, 1'b0};
            tcp_check_idx = {1'b0, hdr_end} + 7'(TCP_CHECK_OFS);

            take_ip   = in_range && (word_index_reg < index_t'(hdr_end)) &&
                        (word_index_reg != IDX_IP_CHECK);
            take_addr = in_range && (word_index_reg >= IDX_ADDR_FIRST) &&
                        (word_index_reg <= IDX_ADDR_LAST);
            take_seg  = in_range && (word_index_reg >= index_t'(hdr_end)) &&
                        (word_index_reg != index_t'(tcp_check_idx));

            if (take_ip)
                ip_sum_next = oc_add(ip_sum_reg, w_eff);
            tcp_mid = take_addr ? oc_add(tcp_sum_reg, w_eff) : tcp_sum_reg;
            tcp_sum_next = take_seg ? oc_add(tcp_mid, w_eff) : tcp_mid;

            // Stop counting at the last representable index
            if (word_index_reg == INDEX_MAX)
                past_end_next = 1'b1;
            else
                word_index_next = word_index_reg + index_t'(1);
        end

        // Pseudo-header terms and end-of-packet checks
        seg_len     = total_length_next - {10'd0, header_words_next, 2'b00};
        tcp_fin     = oc_add(oc_add(tcp_sum_next, {8'd0, protocol_next}), seg_len);
        count       = past_end_next ? 16'h8000 : {1'b0, word_index_next};
        count_bytes = {count, 1'b0};

        ip_checksum_next  = ~ip_sum_next;
        tcp_checksum_next = ~tcp_fin;
        length_error_next = (header_words_next < IHL_MIN) ||
                            (count_bytes < {1'b0, total_length_next});
    end

    // Control and packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            word_index_reg   <= '0;
            past_end_reg     <= 1'b0;
            header_words_reg <= '0;
            total_length_reg <= '0;
            protocol_reg     <= '0;
            ip_sum_reg       <= '0;
            tcp_sum_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;

            if (advance && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                if (last_reg)
                begin
                    // Clear for the next packet
                    word_index_reg   <= '0;
                    past_end_reg     <= 1'b0;
                    header_words_reg <= '0;
                    total_length_reg <= '0;
                    protocol_reg     <= '0;
                    ip_sum_reg       <= '0;
                    tcp_sum_reg      <= '0;
                end
                else
                begin
                    word_index_reg   <= word_index_next;
                    past_end_reg     <= past_end_next;
                    header_words_reg <= header_words_next;
                    total_length_reg <= total_length_next;
                    protocol_reg     <= protocol_next;
                    ip_sum_reg       <= ip_sum_next;
                    tcp_sum_reg      <= tcp_sum_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word;
            last_reg <= last;
        end
        if (advance && last_reg)
        begin
            ip_checksum_reg  <= ip_checksum_next;
            tcp_checksum_reg <= tcp_checksum_next;
            length_error_reg <= length_error_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ip_checksum  = ip_checksum_reg;
    assign tcp_checksum = tcp_checksum_reg;
    assign length_error = length_error_reg;

endmodule

// ===== rtl/ipcs_checker.sv =====
// ============================================================================
// ipcs_checker: port-level checks for the checksum stream core
// Watches the handshakes and result timing on the top-level ports.
// ============================================================================
module ipcs_checker
    import ipcs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  last,
    input logic  out_valid,
    input logic  out_ready,
    input word_t ip_checksum,
    input word_t tcp_checksum,
    input logic  length_error
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ip_checksum) &&
            $stable(tcp_checksum) && $stable(length_error))
        else $error("stalled result changed or dropped");

    // Input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A fresh result follows a last word that went through the input register
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last, 2))
        else $error("result without a preceding last word");

endmodule

bind ipv4_tcp_checksum_stream_core ipcs_checker u_ipcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ip_checksum  (ip_checksum),
    .tcp_checksum (tcp_checksum),
    .length_error (length_error)
);

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for the IPv4/TCP checksum stream core
// Streams IPv4/TCP packets word by word through the core and checks every
// result against a cycle-free model of both checksums and the length flag,
// or, for typed directed rows, against their hand-computed result.
module tb_top;

    import ipcs_pkg::*;

    localparam int RANDOM_WORDS     = 1900;
    localparam int LONG_HOLD_AT     = 10;      // result count that starts the long hold
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 1000000;

    // One expected result of a packet
    typedef struct packed {
        word_t ip;
        word_t tcp;
        logic  err;
    } csum_result_t;

    // One row of the directed table; typed rows carry a hand-computed result
    typedef struct packed {
        word_t w;
        logic  last;
        logic  typed;
        word_t want_ip;
        word_t want_tcp;
        logic  want_err;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;

    // Two single-word packets (all zeros, all ones), then a textbook packet:
    // ten-word (20-byte) header, 41 bytes in all, so the final word carries one pad byte.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, 1'b1, 16'hffff, 16'hffff, 1'b1},
        '{16'hffff, 1'b1, 1'b1, 16'h0000, 16'h003b, 1'b0},
        '{16'h4500, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0029, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h1c46, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h4000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h4006, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hb1e6, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hac10, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0a63, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hac10, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0a0c, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h3039, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0050, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h5018, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h7210, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hbeef, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h41ff, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [15:0] word      = 16'h0000;
    logic        last      = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic        length_error;

    always #2 clk = ~clk;

    ipv4_tcp_checksum_stream_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word         (word),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ip_checksum  (ip_checksum),
        .tcp_checksum (tcp_checksum),
        .length_error (length_error)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    csum_result_t pending_sums [$];   // results owed by the core, oldest first
    int           mismatches    = 0;
    int           words_sent    = 0;
    int           results_seen  = 0;
    int           cycle_count   = 0;
    bit           send_idle_on  = 1'b1;
    bit           recv_idle_on  = 1'b1;

    // Packet state of the checksum model
    index_t pkt_index;
    ihl_t   pkt_ihl;
    word_t  pkt_total_len;
    proto_t pkt_proto;
    word_t  pkt_ip_sum;
    word_t  pkt_tcp_sum;
    logic   pkt_past_end;

    // ------------------------------------------------------------------------
    // Checksum model
    // ------------------------------------------------------------------------
    function automatic word_t ones_sum(input word_t a, input word_t b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        // fold the carry back in; cannot carry out a second time
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_packet_state();
        pkt_index     = '0;
        pkt_ihl       = '0;
        pkt_total_len = '0;
        pkt_proto     = '0;
        pkt_ip_sum    = '0;
        pkt_tcp_sum   = '0;
        pkt_past_end  = 1'b0;
    endtask

    // Advance the model by one accepted word; on the last word hand back
    // the packet's checksums and clear for the next packet.
    task automatic sum_packet_word(input word_t w_in, input logic is_last,
                                   output logic has_res, output csum_result_t res);
        int unsigned idx;
        int unsigned bytes;
        int unsigned hdr_end;
        int unsigned count;
        logic        in_range;
        word_t       w;
        word_t       seg_len;
        word_t       t;
        w       = w_in;
        has_res = 1'b0;
        res     = '0;
        if (!pkt_past_end)
        begin
            idx   = pkt_index;
            bytes = 2 * idx;
            // latch the header fields before classing the word
            if (idx == IDX_IHL)       pkt_ihl       = w[11:8];
            if (idx == IDX_TOTAL_LEN) pkt_total_len = w;
            if (idx == IDX_PROTOCOL)  pkt_proto     = w[7:0];

            in_range = (idx < IDX_FIRST_VAR) || (bytes < pkt_total_len);
            // odd total length: drop the byte past the end
            if (idx >= IDX_FIRST_VAR && bytes + 1 == pkt_total_len)
                w = w & ~LOW_BYTE_MASK;

            if (in_range)
            begin
                hdr_end = 2 * pkt_ihl;
                if (idx < hdr_end && idx != IDX_IP_CHECK)
                    pkt_ip_sum = ones_sum(pkt_ip_sum, w);
                if (idx >= IDX_ADDR_FIRST && idx <= IDX_ADDR_LAST)
                    pkt_tcp_sum = ones_sum(pkt_tcp_sum, w);
                if (idx >= hdr_end && idx != hdr_end + TCP_CHECK_OFS)
                    pkt_tcp_sum = ones_sum(pkt_tcp_sum, w);
            end

            if (idx >= INDEX_MAX) pkt_past_end = 1'b1;
            else                  pkt_index    = index_t'(idx + 1);
        end

        if (is_last)
        begin
            // fold in the pseudo-header: protocol and segment length
            seg_len = pkt_total_len - word_t'({pkt_ihl, 2'b00});
            t       = ones_sum(pkt_tcp_sum, word_t'(pkt_proto));
            t       = ones_sum(t, seg_len);
            count   = pkt_past_end ? (int'(INDEX_MAX) + 1) : int'(pkt_index);
            res.ip  = ~pkt_ip_sum;
            res.tcp = ~t;
            res.err = (pkt_ihl < IHL_MIN) || (2 * count < pkt_total_len);
            has_res = 1'b1;
            clear_packet_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0d] ERROR: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_result(input csum_result_t got);
        csum_result_t want;
        if (pending_sums.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: ip=%h tcp=%h err=%b",
                                      got.ip, got.tcp, got.err));
            return;
        end
        want = pending_sums.pop_front();
        if (got.ip !== want.ip)
            report_mismatch($sformatf("ip_checksum %h, want %h", got.ip, want.ip));
        if (got.tcp !== want.tcp)
            report_mismatch($sformatf("tcp_checksum %h, want %h", got.tcp, want.tcp));
        if (got.err !== want.err)
            report_mismatch($sformatf("length_error %b, want %b", got.err, want.err));
    endtask

    // ------------------------------------------------------------------------
    // Word source side
    // ------------------------------------------------------------------------
    // Offer one word after a random gap and hold it until accepted. Check
    // in_ready at the falling edge so the decision never races the core's
    // own update at the rising edge. Lower valid only when a gap follows.
    task automatic offer_word(input word_t w, input logic is_last,
                              input logic typed, input csum_result_t typed_want);
        int           gap;
        logic         has_res;
        csum_result_t res;
        gap = send_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        word     <= w;
        last     <= is_last;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        // the word is taken at this edge
        sum_packet_word(w, is_last, has_res, res);
        if (has_res) pending_sums.push_back(typed ? typed_want : res);
        words_sent++;
    endtask

    // Build one packet: mostly well-formed headers with random content,
    // plus short headers, early ends, trailing junk, odd, wild or too-short
    // total lengths and plain noise.
    task automatic send_random_packet();
        int    kind;
        int    n_words;
        int    seg_bytes;
        ihl_t  ihl;
        word_t total;
        word_t w;
        kind      = $urandom_range(0, 15);
        ihl       = ($urandom_range(0, 2) == 0) ? ihl_t'($urandom_range(5, 15)) : IHL_MIN;
        if (kind == 0) ihl = ihl_t'($urandom_range(0, 4));
        seg_bytes = $urandom_range(0, 48);
        total     = word_t'(4 * ihl + seg_bytes);
        n_words   = (total + 1) / 2;
        case (kind)
            1: n_words = $urandom_range(1, n_words);               // early end
            2: n_words = n_words + $urandom_range(1, 6);           // junk past the end
            3: total   = word_t'($urandom_range(0, 4 * ihl));      // total up to the header length
            4: total   = word_t'($urandom);                        // wild total length
            5: n_words = $urandom_range(1, 24);                    // noise
            default: ;
        endcase
        if (n_words < 1) n_words = 1;
        send_idle_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n_words; i++)
        begin
            if (kind == 5)   w = word_t'($urandom);
            else if (i == 0) w = {4'($urandom), ihl, 8'($urandom)};
            else if (i == 1) w = total;
            else             w = word_t'($urandom);
            offer_word(w, i == n_words - 1, 1'b0, '0);
        end
    endtask

    initial
    begin : word_source
        csum_result_t typed_want;
        bit           paused;
        paused = 1'b0;
        clear_packet_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            typed_want = '{DIRECTED[r].want_ip, DIRECTED[r].want_tcp, DIRECTED[r].want_err};
            offer_word(DIRECTED[r].w, DIRECTED[r].last, DIRECTED[r].typed, typed_want);
        end

        // Random packets; once, halfway, drain every pending result first
        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS)
        begin
            if (!paused && words_sent > DIRECTED_ROWS + RANDOM_WORDS / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (pending_sums.size() != 0) @(posedge clk);
                @(posedge clk);
            end
            send_random_packet();
        end
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ipv4_tcp_checksum_stream_core: match");
        else
            $display("ipv4_tcp_checksum_stream_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink side
    // ------------------------------------------------------------------------
    // Stall a random number of cycles before each result, switch between
    // stalling and streaming now and then, and hold off once for a long
    // stretch so the core fills up and drops in_ready.
    initial
    begin : result_sink
        csum_result_t got;
        int           stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_idle_on ? $urandom_range(0, 4) : 0;
            if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            got = '{ip_checksum, tcp_checksum, length_error};
            @(posedge clk);
            // the result is taken at this edge
            check_result(got);
            results_seen++;
            if ($urandom_range(0, 7) == 0) recv_idle_on = !recv_idle_on;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0d] timeout with %0d results pending", cycle_count,
                     pending_sums.size());
            $display("ipv4_tcp_checksum_stream_core: mismatch");
            $finish;
        end
    end

endmodule
